@@ design/btop_pkg.sv @@
// shared types and constants of the binomial tree option pricer
// used by the cell row, the sequencer and the top level; no dependencies
package btop_pkg;

  localparam int MAX_STEPS = 256;
  localparam int NODE_CNT  = MAX_STEPS + 1;
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);
  localparam int VAL_W     = 48;
  localparam int HALF_W    = 24;
  localparam int FAC_W     = 32;
  localparam int PRB_W     = 31;
  localparam int PROD_W    = HALF_W + FAC_W;
  localparam int ACC_W     = VAL_W + FAC_W;
  localparam int FRAC_W    = 30;

  localparam logic [PRB_W-1:0] ONE_Q30 = PRB_W'(1) << FRAC_W;

  // operation broadcast to every cell in the same cycle
  typedef enum logic [3:0] {
    OP_HOLD,
    OP_LOAD,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_PAYOFF,
    OP_BL_A,
    OP_BL_B,
    OP_BL_C,
    OP_BL_D
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic                  leaf;
    logic [CNT_W-1:0]      lim;
    logic [CNT_W-1:0]      ups;
    logic [FAC_W-1:0]      up_f;
    logic [FAC_W-1:0]      down_f;
    logic [PRB_W-1:0]      prob;
    logic [PRB_W-1:0]      qprob;
    logic [PRB_W-1:0]      disc;
    logic [VAL_W-1:0]      spot;
    logic [VAL_W-1:0]      strike;
    logic                  put;
  } cell_ctl_t;

endpackage

@@ design/btop_cell.sv @@
// one tree node cell: holds a node value, its saturation flag and a partial product sum
// depends on btop_pkg; reads the value of the next cell up the row
module btop_cell (
  input  logic                         clk,
  input  btop_pkg::cell_ctl_t          ctl,
  input  logic [btop_pkg::CNT_W-1:0]   cell_idx,
  input  logic [btop_pkg::VAL_W-1:0]   nbr_value,
  input  logic                         nbr_sat,
  output logic [btop_pkg::VAL_W-1:0]   node_value,
  output logic                         node_sat
);

  logic [btop_pkg::VAL_W-1:0]  value_r, value_nxt;
  logic [btop_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic                        sat_r, sat_nxt;

  logic                        active;
  logic [btop_pkg::FAC_W-1:0]  mul_factor;
  logic [btop_pkg::HALF_W-1:0] op_a;
  logic [btop_pkg::FAC_W-1:0]  op_b;
  logic                        hi_sel;
  logic [btop_pkg::PROD_W-1:0] prod;
  logic [btop_pkg::ACC_W-1:0]  prod_ext;
  logic [btop_pkg::ACC_W-1:0]  sum;
  logic [btop_pkg::VAL_W-1:0]  payoff;

  // which cells take part: leaves 0..N, fold nodes below the level
  always_comb begin
    if (ctl.leaf) begin
      active = (cell_idx <= ctl.lim);
    end else begin
      active = (cell_idx < ctl.lim);
    end
    if (ctl.leaf) begin
      mul_factor = (cell_idx < ctl.ups) ? ctl.up_f : ctl.down_f;
    end else begin
      mul_factor = btop_pkg::FAC_W'(ctl.disc);
    end
  end

  // operand selection for the shared partial product multiplier
  always_comb begin
    op_a   = value_r[btop_pkg::HALF_W-1:0];
    op_b   = mul_factor;
    hi_sel = 1'b0;
    unique case (ctl.op)
      btop_pkg::OP_MUL_HI: begin
        op_a   = value_r[btop_pkg::VAL_W-1:btop_pkg::HALF_W];
        hi_sel = 1'b1;
      end
      btop_pkg::OP_BL_A: begin
        op_a   = value_r[btop_pkg::VAL_W-1:btop_pkg::HALF_W];
        op_b   = btop_pkg::FAC_W'(ctl.prob);
        hi_sel = 1'b1;
      end
      btop_pkg::OP_BL_B: begin
        op_a   = nbr_value[btop_pkg::VAL_W-1:btop_pkg::HALF_W];
        op_b   = btop_pkg::FAC_W'(ctl.qprob);
        hi_sel = 1'b1;
      end
      btop_pkg::OP_BL_C: begin
        op_b   = btop_pkg::FAC_W'(ctl.prob);
      end
      btop_pkg::OP_BL_D: begin
        op_a   = nbr_value[btop_pkg::HALF_W-1:0];
        op_b   = btop_pkg::FAC_W'(ctl.qprob);
      end
      default: begin
      end
    endcase
  end

  // partial product, aligned and added to the running sum
  always_comb begin
    prod = btop_pkg::PROD_W'(op_a) * btop_pkg::PROD_W'(op_b);
    if (hi_sel) begin
      prod_ext = btop_pkg::ACC_W'(prod) << btop_pkg::HALF_W;
    end else begin
      prod_ext = btop_pkg::ACC_W'(prod);
    end
    sum = acc_r + prod_ext;
  end

  // call or put payoff against the strike
  always_comb begin
    if (ctl.put) begin
      payoff = (ctl.strike > value_r) ? (ctl.strike - value_r) : '0;
    end else begin
      payoff = (value_r > ctl.strike) ? (value_r - ctl.strike) : '0;
    end
  end

  // next state of the cell
  always_comb begin
    value_nxt = value_r;
    acc_nxt   = acc_r;
    sat_nxt   = sat_r;
    unique case (ctl.op)
      btop_pkg::OP_HOLD: begin
      end
      btop_pkg::OP_LOAD: begin
        value_nxt = ctl.spot;
        sat_nxt   = 1'b0;
      end
      btop_pkg::OP_MUL_HI, btop_pkg::OP_BL_A: begin
        if (active) begin
          acc_nxt = prod_ext;
        end
      end
      btop_pkg::OP_BL_B, btop_pkg::OP_BL_C: begin
        if (active) begin
          acc_nxt = sum;
        end
      end
      btop_pkg::OP_MUL_LO: begin
        if (active) begin
          if (sum[btop_pkg::ACC_W-1:btop_pkg::VAL_W+btop_pkg::FRAC_W] != '0) begin
            value_nxt = '1;
            sat_nxt   = 1'b1;
          end else begin
            value_nxt = sum[btop_pkg::VAL_W+btop_pkg::FRAC_W-1:btop_pkg::FRAC_W];
          end
        end
      end
      btop_pkg::OP_BL_D: begin
        if (active) begin
          value_nxt = sum[btop_pkg::VAL_W+btop_pkg::FRAC_W-1:btop_pkg::FRAC_W];
          sat_nxt   = sat_r | nbr_sat;
        end
      end
      btop_pkg::OP_PAYOFF: begin
        if (active) begin
          value_nxt = payoff;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    acc_r   <= acc_nxt;
    sat_r   <= sat_nxt;
  end

  assign node_value = value_r;
  assign node_sat   = sat_r;

endmodule

@@ design/btop_seq.sv @@
// sequencer: takes one input word, steps the cell row through leaves, payoff and fold
// depends on btop_pkg; drives the broadcast control of all cells
module btop_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [btop_pkg::VAL_W-1:0]   spot_price,
  input  logic [btop_pkg::VAL_W-1:0]   strike_price,
  input  logic                         is_put,
  input  logic [8:0]                   step_count,
  input  logic [btop_pkg::FAC_W-1:0]   up_factor,
  input  logic [btop_pkg::FAC_W-1:0]   down_factor,
  input  logic [btop_pkg::PRB_W-1:0]   up_probability,
  input  logic [btop_pkg::PRB_W-1:0]   step_discount,
  input  logic                         slot_free,
  output logic                         res_load,
  output btop_pkg::cell_ctl_t          ctl
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_LEAF_HI, S_LEAF_LO, S_PAY,
    S_BL_A, S_BL_B, S_BL_C, S_BL_D, S_DSC_HI, S_DSC_LO, S_DONE
  } seq_state_t;

  localparam logic [btop_pkg::CNT_W-1:0] MAX_N = btop_pkg::CNT_W'(btop_pkg::MAX_STEPS);
  localparam logic [btop_pkg::CNT_W-1:0] CNT_ONE = btop_pkg::CNT_W'(1);

  seq_state_t                  state_r;
  logic [btop_pkg::CNT_W-1:0]  n_r;
  logic [btop_pkg::CNT_W-1:0]  cnt_r;
  logic [btop_pkg::VAL_W-1:0]  spot_r;
  logic [btop_pkg::VAL_W-1:0]  strike_r;
  logic                        put_r;
  logic [btop_pkg::PRB_W-1:0]  p_r;
  logic [btop_pkg::PRB_W-1:0]  q_r;

  logic [btop_pkg::CNT_W-1:0]  n_clip;
  logic [btop_pkg::PRB_W-1:0]  p_clip;

  // clip step count and probability when a word is taken
  always_comb begin
    if (32'(step_count) > 32'(btop_pkg::MAX_STEPS)) begin
      n_clip = MAX_N;
    end else begin
      n_clip = btop_pkg::CNT_W'(step_count);
    end
    p_clip = (up_probability > btop_pkg::ONE_Q30) ? btop_pkg::ONE_Q30 : up_probability;
  end

  assign in_ready = (state_r == S_IDLE);
  assign res_load = (state_r == S_DONE) && slot_free;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      n_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            spot_r   <= spot_price;
            strike_r <= strike_price;
            put_r    <= is_put;
            n_r      <= n_clip;
            cnt_r    <= n_clip;
            p_r      <= p_clip;
            q_r      <= btop_pkg::ONE_Q30 - p_clip;
            state_r  <= S_LOAD;
          end
        end
        S_LOAD: begin
          state_r <= (n_r == '0) ? S_PAY : S_LEAF_HI;
        end
        S_LEAF_HI: begin
          state_r <= S_LEAF_LO;
        end
        S_LEAF_LO: begin
          cnt_r   <= cnt_r - CNT_ONE;
          state_r <= (cnt_r == CNT_ONE) ? S_PAY : S_LEAF_HI;
        end
        S_PAY: begin
          cnt_r   <= n_r;
          state_r <= (n_r == '0) ? S_DONE : S_BL_A;
        end
        S_BL_A:   state_r <= S_BL_B;
        S_BL_B:   state_r <= S_BL_C;
        S_BL_C:   state_r <= S_BL_D;
        S_BL_D:   state_r <= S_DSC_HI;
        S_DSC_HI: state_r <= S_DSC_LO;
        S_DSC_LO: begin
          cnt_r   <= cnt_r - CNT_ONE;
          state_r <= (cnt_r == CNT_ONE) ? S_DONE : S_BL_A;
        end
        S_DONE: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // broadcast control to the cell row
  always_comb begin
    ctl.op     = btop_pkg::OP_HOLD;
    ctl.leaf   = 1'b1;
    ctl.lim    = n_r;
    ctl.ups    = cnt_r;
    ctl.up_f   = up_factor;
    ctl.down_f = down_factor;
    ctl.prob   = p_r;
    ctl.qprob  = q_r;
    ctl.disc   = step_discount;
    ctl.spot   = spot_r;
    ctl.strike = strike_r;
    ctl.put    = put_r;
    unique case (state_r)
      S_LOAD:    ctl.op = btop_pkg::OP_LOAD;
      S_LEAF_HI: ctl.op = btop_pkg::OP_MUL_HI;
      S_LEAF_LO: ctl.op = btop_pkg::OP_MUL_LO;
      S_PAY:     ctl.op = btop_pkg::OP_PAYOFF;
      S_BL_A, S_BL_B, S_BL_C, S_BL_D, S_DSC_HI, S_DSC_LO: begin
        ctl.leaf = 1'b0;
        ctl.lim  = cnt_r;
        unique case (state_r)
          S_BL_A:   ctl.op = btop_pkg::OP_BL_A;
          S_BL_B:   ctl.op = btop_pkg::OP_BL_B;
          S_BL_C:   ctl.op = btop_pkg::OP_BL_C;
          S_BL_D:   ctl.op = btop_pkg::OP_BL_D;
          S_DSC_HI: ctl.op = btop_pkg::OP_MUL_HI;
          default:  ctl.op = btop_pkg::OP_MUL_LO;
        endcase
      end
      default: ctl.op = btop_pkg::OP_HOLD;
    endcase
  end

endmodule

@@ design/binomial_tree_option_pricer_core.sv @@
// European binomial tree option pricer: a row of MAX_STEPS+1 node cells
// driven by one sequencer; depends on btop_pkg, btop_cell and btop_seq
//
// usage: software writes the step count N, up and down factors, up probability
// and per-step discount over the APB-style cfg_ port while the block is idle.
// each input word (in_ channel) carries spot and strike, tuser selects put.
// every input word yields exactly one result word on the out_ channel: the
// root value in tdata and the saturation flag in tuser.
// sequence: after a word is taken, all leaves are formed in parallel, one
// multiply per leaf per tree level in a high and a low half step, then the
// payoff, then N fold levels, each a probability blend and a discount, every
// cell reading its upper neighbor: the result then reaches the output register,
// and the next word is taken in the cycle after the result is loaded.
// the result waits in the output register while out_tready is low; a new
// input word is still taken then, and its result is held back until the
// register frees. reset (rst_n low, synchronous) empties the pipeline and
// restores the register defaults: N = 256, factors 1.0, probability 0.5,
// discount 1.0. the node cells themselves need no clearing.
module binomial_tree_option_pricer_core (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [47:0] spot_price, [95:48] strike_price
  input  logic        in_tuser,   // [0] is_put
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [47:0] option_value
  output logic        out_tuser,  // [0] saturated
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [2:0] {
    REG_STEP_COUNT     = 3'd0,
    REG_UP_FACTOR      = 3'd1,
    REG_DOWN_FACTOR    = 3'd2,
    REG_UP_PROBABILITY = 3'd3,
    REG_STEP_DISCOUNT  = 3'd4
  } reg_idx_t;

  logic [8:0]                  step_count_r;
  logic [btop_pkg::FAC_W-1:0]  up_factor_r;
  logic [btop_pkg::FAC_W-1:0]  down_factor_r;
  logic [btop_pkg::PRB_W-1:0]  up_probability_r;
  logic [btop_pkg::PRB_W-1:0]  step_discount_r;

  logic                        cfg_wr;
  logic [2:0]                  cfg_idx;

  logic                        out_valid_r;
  logic [btop_pkg::VAL_W-1:0]  out_value_r;
  logic                        out_sat_r;

  logic                        slot_free;
  logic                        res_load;
  btop_pkg::cell_ctl_t         ctl;

  logic [btop_pkg::VAL_W-1:0]  node_val_w [btop_pkg::NODE_CNT];
  logic                        node_sat_w [btop_pkg::NODE_CNT];

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r     <= 9'd256;
      up_factor_r      <= btop_pkg::FAC_W'(btop_pkg::ONE_Q30);
      down_factor_r    <= btop_pkg::FAC_W'(btop_pkg::ONE_Q30);
      up_probability_r <= btop_pkg::ONE_Q30 >> 1;
      step_discount_r  <= btop_pkg::ONE_Q30;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_STEP_COUNT:     step_count_r     <= cfg_pwdata[8:0];
        REG_UP_FACTOR:      up_factor_r      <= cfg_pwdata;
        REG_DOWN_FACTOR:    down_factor_r    <= cfg_pwdata;
        REG_UP_PROBABILITY: up_probability_r <= cfg_pwdata[btop_pkg::PRB_W-1:0];
        REG_STEP_DISCOUNT:  step_discount_r  <= cfg_pwdata[btop_pkg::PRB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_STEP_COUNT:     cfg_prdata = 32'(step_count_r);
      REG_UP_FACTOR:      cfg_prdata = up_factor_r;
      REG_DOWN_FACTOR:    cfg_prdata = down_factor_r;
      REG_UP_PROBABILITY: cfg_prdata = 32'(up_probability_r);
      REG_STEP_DISCOUNT:  cfg_prdata = 32'(step_discount_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // sequencer
  assign slot_free = !out_valid_r || out_tready;

  btop_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .spot_price     (in_tdata[47:0]),
    .strike_price   (in_tdata[95:48]),
    .is_put         (in_tuser),
    .step_count     (step_count_r),
    .up_factor      (up_factor_r),
    .down_factor    (down_factor_r),
    .up_probability (up_probability_r),
    .step_discount  (step_discount_r),
    .slot_free      (slot_free),
    .res_load       (res_load),
    .ctl            (ctl)
  );

  // row of node cells, each reading its upper neighbor
  for (genvar g = 0; g < btop_pkg::NODE_CNT; g++) begin : g_cell
    if (g < btop_pkg::NODE_CNT - 1) begin : g_mid
      btop_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .cell_idx   (btop_pkg::CNT_W'(g)),
        .nbr_value  (node_val_w[g+1]),
        .nbr_sat    (node_sat_w[g+1]),
        .node_value (node_val_w[g]),
        .node_sat   (node_sat_w[g])
      );
    end else begin : g_top
      btop_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .cell_idx   (btop_pkg::CNT_W'(g)),
        .nbr_value  ('0),
        .nbr_sat    (1'b0),
        .node_value (node_val_w[g]),
        .node_sat   (node_sat_w[g])
      );
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_value_r <= node_val_w[0];
      out_sat_r   <= node_sat_w[0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_sat_r;

endmodule
